@@ hdl/dyd_pkg.sv @@
package dyd_pkg;

    localparam int HEADER_BYTES = 48;
    localparam int TAB_AW       = $clog2(HEADER_BYTES);
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 1);
    localparam int GROUP_W      = 10;
    localparam int LINE_W       = 12;
    localparam int GPL_W        = 11;
    localparam int LC_W         = 13;
    localparam int COORD_W      = 12;

    localparam logic [GPL_W-1:0] MAX_GROUPS = 11'd1024;
    localparam logic [LC_W-1:0]  MAX_LINES  = 13'd4096;

    localparam logic [TAB_AW-1:0] YBASE_NORM = 6'd0;
    localparam logic [TAB_AW-1:0] YBASE_ALT  = 6'd16;
    localparam logic [TAB_AW-1:0] UBASE_NORM = 6'd16;
    localparam logic [TAB_AW-1:0] UBASE_ALT  = 6'd32;
    localparam logic [TAB_AW-1:0] VBASE      = 6'd32;

    localparam logic [1:0] REG_GPL    = 2'd0;
    localparam logic [1:0] REG_LC     = 2'd1;
    localparam logic [1:0] REG_LAYOUT = 2'd2;

    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } t_plane;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // Clamped geometry and layout as seen by the datapath.
    typedef struct packed {
        logic [GPL_W-1:0] gpl;
        logic [LC_W-1:0]  lc;
        logic             layout;
    } t_cfg;

    // Everything the reconstruction stage needs to know about one pixel byte.
    typedef struct packed {
        t_phase              phase;
        logic                first;
        logic [7:0]          data;
        logic [LINE_W-1:0]   row;
        logic [GROUP_W-1:0]  grp;
        logic                eof;
    } t_tag;

    typedef struct packed {
        t_plane              plane;
        logic [7:0]          sample;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  column;
        logic                last;
        logic                eof;
    } t_sample;

endpackage

@@ hdl/dyd_in_if.sv @@
interface dyd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       frame_start;

    modport source (output valid, output stream_byte, output frame_start, input ready);
    modport sink   (input valid, input stream_byte, input frame_start, output ready);
endinterface

@@ hdl/dyd_out_if.sv @@
interface dyd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  plane;
    logic [7:0]  sample;
    logic [11:0] row;
    logic [11:0] column;
    logic        last_of_run;
    logic        end_of_frame;

    modport source (output valid, output plane, output sample, output row, output column,
                    output last_of_run, output end_of_frame, input ready);
    modport sink   (input valid, input plane, input sample, input row, input column,
                    input last_of_run, input end_of_frame, output ready);
endinterface

@@ hdl/dyd_regs.sv @@
module dyd_regs import dyd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [GPL_W-1:0] r_gpl;
    logic [LC_W-1:0]  r_lc;
    logic             r_layout;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl    <= 11'd80;
            r_lc     <= 13'd240;
            r_layout <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_GPL:    r_gpl    <= pwdata[GPL_W-1:0];
                REG_LC:     r_lc     <= pwdata[LC_W-1:0];
                REG_LAYOUT: r_layout <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GPL:    prdata = {{(32-GPL_W){1'b0}}, r_gpl};
            REG_LC:     prdata = {{(32-LC_W){1'b0}}, r_lc};
            REG_LAYOUT: prdata = {31'd0, r_layout};
            default:    prdata = 32'd0;
        endcase
    end

    // Out-of-range geometry saturates to the supported range.
    always_comb begin
        if (r_gpl == '0)
            o_cfg.gpl = 11'd1;
        else if (r_gpl > MAX_GROUPS)
            o_cfg.gpl = MAX_GROUPS;
        else
            o_cfg.gpl = r_gpl;

        if (r_lc == '0)
            o_cfg.lc = 13'd1;
        else if (r_lc > MAX_LINES)
            o_cfg.lc = MAX_LINES;
        else
            o_cfg.lc = r_lc;

        o_cfg.layout = r_layout;
    end

endmodule

@@ hdl/dyd_table.sv @@
module dyd_table import dyd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [TAB_AW-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [TAB_AW-1:0] i_raddr_a,
    input  logic [TAB_AW-1:0] i_raddr_b,
    output logic [7:0]        o_rdata_a,
    output logic [7:0]        o_rdata_b
);

    logic [7:0] mem [HEADER_BYTES];

    // Read data is captured only when a pixel byte enters, so it holds while
    // the reconstruction stage waits.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

@@ hdl/dyd_parse.sv @@
module dyd_parse import dyd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_fs,
    output logic              o_we,
    output logic [TAB_AW-1:0] o_waddr,
    output logic              o_load,
    output logic [TAB_AW-1:0] o_raddr_a,
    output logic [TAB_AW-1:0] o_raddr_b,
    output t_tag              o_tag
);

    logic [HDR_CNT_W-1:0] r_hc,    n_hc;
    t_phase               r_phase, n_phase;
    logic [GROUP_W-1:0]   r_grp,   n_grp;
    logic [LINE_W-1:0]    r_line,  n_line;
    logic                 r_done,  n_done;

    logic [HDR_CNT_W-1:0] hc;
    t_phase               ph;
    logic [GROUP_W-1:0]   grp;
    logic [LINE_W-1:0]    line;
    logic                 active;
    logic                 is_hdr;
    logic                 g_last;
    logic                 l_last;
    logic [TAB_AW-1:0]    ybase;
    logic [TAB_AW-1:0]    ubase;
    logic [TAB_AW-1:0]    lo_n;
    logic [TAB_AW-1:0]    hi_n;

    // A frame start byte sees the state as freshly restarted.
    assign hc   = i_fs ? '0 : r_hc;
    assign ph   = i_fs ? PH_FIRST : r_phase;
    assign grp  = i_fs ? '0 : r_grp;
    assign line = i_fs ? '0 : r_line;

    assign active = i_accept && (i_fs || !r_done);
    assign is_hdr = hc < HDR_CNT_W'(HEADER_BYTES);

    assign g_last = ({1'b0, grp} + 11'd1) >= i_cfg.gpl;
    assign l_last = ({1'b0, line} + 13'd1) >= i_cfg.lc;

    assign ybase = i_cfg.layout ? YBASE_ALT : YBASE_NORM;
    assign ubase = i_cfg.layout ? UBASE_ALT : UBASE_NORM;
    assign lo_n  = {2'b00, i_byte[3:0]};
    assign hi_n  = {2'b00, i_byte[7:4]};

    assign o_we    = active && is_hdr;
    assign o_waddr = hc[TAB_AW-1:0];
    assign o_load  = active && !is_hdr;

    always_comb begin
        unique case (ph)
            PH_FIRST: begin
                o_raddr_a = ubase + hi_n;
                o_raddr_b = ybase + lo_n;
            end
            PH_SECOND: begin
                o_raddr_a = VBASE + hi_n;
                o_raddr_b = ybase + lo_n;
            end
            PH_THIRD: begin
                o_raddr_a = ybase + lo_n;
                o_raddr_b = ybase + hi_n;
            end
            default: begin
                o_raddr_a = ubase + hi_n;
                o_raddr_b = ybase + lo_n;
            end
        endcase
    end

    always_comb begin
        o_tag.phase = ph;
        o_tag.first = (grp == '0);
        o_tag.data  = i_byte;
        o_tag.row   = line;
        o_tag.grp   = grp;
        o_tag.eof   = g_last && l_last;
    end

    always_comb begin
        n_hc    = r_hc;
        n_phase = r_phase;
        n_grp   = r_grp;
        n_line  = r_line;
        n_done  = r_done;
        if (active) begin
            n_done  = 1'b0;
            n_hc    = hc;
            n_phase = ph;
            n_grp   = grp;
            n_line  = line;
            if (is_hdr) begin
                n_hc = hc + 1'b1;
            end else begin
                unique case (ph)
                    PH_FIRST:  n_phase = PH_SECOND;
                    PH_SECOND: n_phase = PH_THIRD;
                    PH_THIRD: begin
                        n_phase = PH_FIRST;
                        if (g_last) begin
                            n_grp = '0;
                            if (l_last) begin
                                n_line = '0;
                                n_done = 1'b1;
                            end else begin
                                n_line = line + 1'b1;
                            end
                        end else begin
                            n_grp = grp + 1'b1;
                        end
                    end
                    default:   n_phase = PH_FIRST;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc    <= '0;
            r_phase <= PH_FIRST;
            r_grp   <= '0;
            r_line  <= '0;
            r_done  <= 1'b1;
        end else begin
            r_hc    <= n_hc;
            r_phase <= n_phase;
            r_grp   <= n_grp;
            r_line  <= n_line;
            r_done  <= n_done;
        end
    end

endmodule

@@ hdl/dyd_recon.sv @@
module dyd_recon import dyd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_tag       i_tag,
    input  logic [7:0] i_da,
    input  logic [7:0] i_db,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_sample    o_word
);

    logic       r_s2_valid;
    t_tag       r_tag;
    logic [7:0] r_luma, n_luma;
    logic [7:0] r_blue, n_blue;
    logic [7:0] r_red,  n_red;
    t_sample    r_head;
    t_sample    r_next;
    logic [1:0] r_cnt;

    t_sample    s0;
    t_sample    s1;
    logic       pair_free;
    logic       adv;
    logic       out_take;
    logic [7:0] luma_mid;
    logic [COORD_W-1:0] col_uv;

    assign out_take  = (r_cnt != 2'd0) && i_out_ready;
    assign pair_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign adv       = r_s2_valid && pair_free;
    assign o_in_ready  = !r_s2_valid || adv;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_word      = r_head;

    assign col_uv   = {{(COORD_W-GROUP_W){1'b0}}, r_tag.grp};
    assign luma_mid = r_luma + i_da;

    always_comb begin
        n_luma = r_luma;
        n_blue = r_blue;
        n_red  = r_red;

        s0.row  = r_tag.row;
        s0.last = 1'b0;
        s0.eof  = 1'b0;
        s1.row  = r_tag.row;
        s1.last = 1'b1;
        s1.eof  = 1'b0;
        s1.plane = PLANE_Y;

        unique case (r_tag.phase)
            PH_FIRST: begin
                if (r_tag.first) begin
                    n_blue = {r_tag.data[7:4], 4'h0};
                    n_luma = {r_tag.data[3:0], 4'h0};
                end else begin
                    n_blue = r_blue + i_da;
                    n_luma = r_luma + i_db;
                end
                s0.plane  = PLANE_U;
                s0.sample = n_blue;
                s0.column = col_uv;
                s1.sample = n_luma;
                s1.column = {r_tag.grp, 2'd0};
            end
            PH_SECOND: begin
                if (r_tag.first)
                    n_red = {r_tag.data[7:4], 4'h0};
                else
                    n_red = r_red + i_da;
                n_luma = r_luma + i_db;
                s0.plane  = PLANE_V;
                s0.sample = n_red;
                s0.column = col_uv;
                s1.sample = n_luma;
                s1.column = {r_tag.grp, 2'd1};
            end
            default: begin
                // Third byte: two luma steps, low nibble first.
                n_luma = luma_mid + i_db;
                s0.plane  = PLANE_Y;
                s0.sample = luma_mid;
                s0.column = {r_tag.grp, 2'd2};
                s1.sample = n_luma;
                s1.column = {r_tag.grp, 2'd3};
                s1.eof    = r_tag.eof;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_luma     <= 8'd0;
            r_blue     <= 8'd0;
            r_red      <= 8'd0;
        end else begin
            if (i_load)
                r_s2_valid <= 1'b1;
            else if (adv)
                r_s2_valid <= 1'b0;

            if (adv) begin
                r_luma <= n_luma;
                r_blue <= n_blue;
                r_red  <= n_red;
                r_cnt  <= 2'd2;
            end else if (out_take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load)
            r_tag <= i_tag;
        if (adv) begin
            r_head <= s0;
            r_next <= s1;
        end else if (out_take && (r_cnt == 2'd2)) begin
            r_head <= r_next;
        end
    end

endmodule

@@ hdl/dpcm_yuv411_delta_decoder_core.sv @@
// DPCM YUV 4:1:1 delta decoder.
// The input channel takes one compressed byte per word; frame_start marks
// the first byte of a frame. The first 48 bytes of a frame load the delta
// tables and give no output. Every later byte up to the frame's end yields
// two sample words on the output channel, each tagged with plane, row and
// column. The user must write configuration over the APB port only while
// the block is idle, which the block does not enforce: groups per line at
// 0x0, line count at 0x4, table layout at 0x8. Table reads and tag of a byte
// are registered in the reconstruction stage, its two samples at the output.
// The output carries one sample per cycle while the receiver is ready, and
// a new pixel byte can enter while the last one's samples leave; table and
// ignored bytes are taken one per cycle unless a byte waits for the output.
// After reset the tables hold no defined data and the decoder ignores
// bytes until one arrives with frame_start set.
// When the receiver stalls, the output holds its word, one more byte waits
// in the reconstruction stage, and then ready drops until space frees.
module dpcm_yuv411_delta_decoder_core import dyd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dyd_in_if.sink      i_in,
    dyd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg              cfg;
    logic              in_ready;
    logic              accept;
    logic              we;
    logic [TAB_AW-1:0] waddr;
    logic              load;
    logic [TAB_AW-1:0] raddr_a;
    logic [TAB_AW-1:0] raddr_b;
    logic [7:0]        rdata_a;
    logic [7:0]        rdata_b;
    t_tag              tag;
    t_sample           word;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    dyd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dyd_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_byte    (i_in.stream_byte),
        .i_fs      (i_in.frame_start),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_load    (load),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .o_tag     (tag)
    );

    dyd_table u_table (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_in.stream_byte),
        .i_re      (load),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    dyd_recon u_recon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_tag       (tag),
        .i_da        (rdata_a),
        .i_db        (rdata_b),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_word      (word)
    );

    assign o_out.plane        = word.plane;
    assign o_out.sample       = word.sample;
    assign o_out.row          = word.row;
    assign o_out.column       = word.column;
    assign o_out.last_of_run  = word.last;
    assign o_out.end_of_frame = word.eof;

endmodule
